@@ sv/nce_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nce_pkg
// shared types and constants of the nonzero coordinate emitter
// ----------------------------------------------------------------------------
package nce_pkg;

    localparam int MAX_RANK   = 6;
    localparam int COORD_BITS = 16;
    localparam int AXIS_BITS  = 3;
    localparam int COUNT_BITS = 32;
    localparam int ELEM_BITS  = 64;
    localparam int DATA_BITS  = 32;
    localparam int ADDR_BITS  = 5;
    localparam int KIND_BITS  = 3;

    // element kinds
    localparam logic [KIND_BITS-1:0] KIND_INT = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_F16 = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_F32 = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_F64 = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_C64 = 3'd4;

    // register indexes (byte address = 4 * index)
    localparam logic [AXIS_BITS-1:0] REG_RANK = 3'd0;
    localparam logic [AXIS_BITS-1:0] REG_KIND = 3'd1;
    localparam logic [AXIS_BITS-1:0] REG_DIM0 = 3'd2;

    typedef struct packed {
        logic [ELEM_BITS-1:0] element_bits;
        logic                 last_element;
    } in_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] coordinate;
        logic [AXIS_BITS-1:0]  axis_number;
        logic                  last_of_run;
        logic [COUNT_BITS-1:0] nonzero_count;
    } out_word_t;

    typedef struct packed {
        logic [AXIS_BITS-1:0]                   rank;
        logic [KIND_BITS-1:0]                   value_kind;
        logic [MAX_RANK-1:0][COORD_BITS-1:0]    dim_size;
    } cfg_t;

    // one nonzero element on its way from front to back
    typedef struct packed {
        logic [MAX_RANK-1:0][COORD_BITS-1:0]    digits;
        logic [AXIS_BITS-1:0]                   rank_m1;
        logic [COUNT_BITS-1:0]                  count;
    } hit_t;

endpackage
`default_nettype wire

@@ sv/nce_cfg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nce_cfg
// apb register file: rank, element kind and axis sizes
// ----------------------------------------------------------------------------
module nce_cfg
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nce_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [nce_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [nce_pkg::DATA_BITS-1:0]     prdata,
    output logic                                   pready,
    output nce_pkg::cfg_t                          cfg
);

    logic [nce_pkg::AXIS_BITS-1:0] index;
    logic [nce_pkg::AXIS_BITS-1:0] dim_sel;
    logic                          wr_en;
    nce_pkg::cfg_t                 cfg_reg;

    assign index   = paddr[nce_pkg::ADDR_BITS-1:2];
    assign dim_sel = index - nce_pkg::REG_DIM0;
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rank       <= nce_pkg::AXIS_BITS'(1);
            cfg_reg.value_kind <= nce_pkg::KIND_INT;
            for (int i = 0; i < nce_pkg::MAX_RANK; i++)
            begin
                cfg_reg.dim_size[i] <= nce_pkg::COORD_BITS'(1);
            end
        end
        else if (wr_en)
        begin
            if (index == nce_pkg::REG_RANK)
            begin
                cfg_reg.rank <= pwdata[nce_pkg::AXIS_BITS-1:0];
            end
            if (index == nce_pkg::REG_KIND)
            begin
                cfg_reg.value_kind <= pwdata[nce_pkg::KIND_BITS-1:0];
            end
            for (int i = 0; i < nce_pkg::MAX_RANK; i++)
            begin
                if (index == nce_pkg::REG_DIM0 + nce_pkg::AXIS_BITS'(i))
                begin
                    cfg_reg.dim_size[i] <= pwdata[nce_pkg::COORD_BITS-1:0];
                end
            end
        end
    end

    always_comb
    begin
        case (index)
            nce_pkg::REG_RANK: prdata = nce_pkg::DATA_BITS'(cfg_reg.rank);
            nce_pkg::REG_KIND: prdata = nce_pkg::DATA_BITS'(cfg_reg.value_kind);
            default:           prdata = nce_pkg::DATA_BITS'(cfg_reg.dim_size[dim_sel]);
        endcase
    end

endmodule
`default_nettype wire

@@ sv/nce_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nce_front
// zero test, odometer and running count; forwards each nonzero element
// ----------------------------------------------------------------------------
module nce_front
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire nce_pkg::in_word_t item,
    input  wire nce_pkg::cfg_t     cfg,
    output logic                   hit_push,
    output nce_pkg::hit_t          hit
);

    localparam logic [30:0] F32_EPS = 31'h3400_0000;
    localparam logic [62:0] F64_EPS = 63'h3CB0_0000_0000_0000;

    logic [nce_pkg::MAX_RANK-1:0][nce_pkg::COORD_BITS-1:0] digits_reg;
    logic [nce_pkg::MAX_RANK-1:0][nce_pkg::COORD_BITS-1:0] digits_next;
    logic [nce_pkg::COUNT_BITS-1:0]                        count_reg;
    logic [nce_pkg::COUNT_BITS-1:0]                        count_inc;
    logic [nce_pkg::AXIS_BITS-1:0]                         rank_eff;
    logic [nce_pkg::AXIS_BITS-1:0]                         rank_m1;
    logic                                                  is_zero;

    // zero test by element kind
    always_comb
    begin
        case (cfg.value_kind)
            nce_pkg::KIND_F16: is_zero = (item.element_bits[14:0] == '0);
            nce_pkg::KIND_F32: is_zero = (item.element_bits[30:0] < F32_EPS);
            nce_pkg::KIND_F64: is_zero = (item.element_bits[62:0] < F64_EPS);
            nce_pkg::KIND_C64: is_zero = (item.element_bits[62:32] == '0) &&
                                         (item.element_bits[30:0] == '0);
            default:           is_zero = (item.element_bits == '0);
        endcase
    end

    // active rank, clamped to 1..MAX_RANK
    always_comb
    begin
        rank_eff = cfg.rank;
        if (cfg.rank == '0)
        begin
            rank_eff = nce_pkg::AXIS_BITS'(1);
        end
        else if (cfg.rank > nce_pkg::AXIS_BITS'(nce_pkg::MAX_RANK))
        begin
            rank_eff = nce_pkg::AXIS_BITS'(nce_pkg::MAX_RANK);
        end
        rank_m1 = rank_eff - 1'b1;
    end

    // odometer step, innermost digit first, carry ripples outward
    always_comb
    begin
        logic [nce_pkg::COORD_BITS-1:0] inc;
        logic                           wrap;
        logic                           carry;
        carry       = 1'b1;
        digits_next = digits_reg;
        for (int a = nce_pkg::MAX_RANK - 1; a >= 0; a--)
        begin
            inc  = digits_reg[a] + 1'b1;
            wrap = (inc == '0) || (inc >= cfg.dim_size[a]);
            if ((nce_pkg::AXIS_BITS'(a) <= rank_m1) && carry)
            begin
                digits_next[a] = wrap ? '0 : inc;
                carry          = wrap;
            end
        end
    end

    // saturating count including this element
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digits_reg <= '0;
            count_reg  <= '0;
        end
        else if (accept)
        begin
            if (item.last_element)
            begin
                digits_reg <= '0;
                count_reg  <= '0;
            end
            else
            begin
                digits_reg <= digits_next;
                if (!is_zero)
                begin
                    count_reg <= count_inc;
                end
            end
        end
    end

    assign hit_push    = accept && !is_zero;
    assign hit.digits  = digits_reg;
    assign hit.rank_m1 = rank_m1;
    assign hit.count   = count_inc;

`ifndef SYNTHESIS
    a_hit_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        hit_push |-> (hit.count != '0))
        else $error("forwarded element carries a zero count");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.last_element) |=> ((digits_reg == '0) && (count_reg == '0)))
        else $error("position or count not cleared after last element");

    a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !item.last_element && !is_zero && (count_reg != '1))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("nonzero count did not advance by one");
`endif

endmodule
`default_nettype wire

@@ sv/nce_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nce_fifo
// short register queue of nonzero elements between front and back
// ----------------------------------------------------------------------------
module nce_fifo
#(
    parameter int DEPTH = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire nce_pkg::hit_t din,
    input  wire logic          pop,
    output nce_pkg::hit_t      dout,
    output logic               empty,
    output logic               full
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    nce_pkg::hit_t         mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic                  do_push;
    logic                  do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/nce_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nce_back
// walks the axes of each queued element, one result word per cycle while results are popped
// ----------------------------------------------------------------------------
module nce_back
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                hit_empty,
    input  wire nce_pkg::hit_t       hit,
    output logic                     hit_pop,
    input  wire logic                pop,
    output logic                     empty,
    output nce_pkg::out_word_t       result
);

    logic [nce_pkg::AXIS_BITS-1:0] axis_reg;
    logic                          out_valid_reg;
    nce_pkg::out_word_t            out_reg;
    logic                          load;
    logic                          at_last;

    // refill the output register when it is free or being taken
    assign load    = !hit_empty && (!out_valid_reg || pop);
    assign at_last = (axis_reg == hit.rank_m1);
    assign hit_pop = load && at_last;
    assign empty   = !out_valid_reg;
    assign result  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
                axis_reg      <= at_last ? '0 : axis_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg.coordinate    <= hit.digits[axis_reg];
            out_reg.axis_number   <= axis_reg;
            out_reg.last_of_run   <= at_last;
            out_reg.nonzero_count <= hit.count;
        end
    end

`ifndef SYNTHESIS
    a_axis_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !hit_empty |-> (axis_reg <= hit.rank_m1))
        else $error("axis counter beyond element rank");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pop && !out_reg.last_of_run)
        |=> (out_valid_reg && (out_reg.axis_number == $past(out_reg.axis_number) + 1'b1)))
        else $error("coordinate run broken before its last axis");

    a_drain_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(out_valid_reg) |-> $past(pop))
        else $error("result word dropped without a pop");
`endif

endmodule
`default_nettype wire

@@ sv/nonzero_coordinate_emitter.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nonzero_coordinate_emitter
// row-major nonzero index extraction with per-axis coordinate words
// ----------------------------------------------------------------------------
// Tensor elements are pushed in row-major order, one word per cycle while
// full is low. The front tests each element for zero under the configured
// kind, keeps the odometer of coordinates and the saturating nonzero count,
// and hands every nonzero element to a queue of QUEUE_DEPTH entries; zero
// elements are absorbed without entering the queue. The back pulls one
// queued element at a time and emits rank result words (1 to 6), outermost
// axis first, one word per cycle while the result port is popped. A nonzero
// element passes through the queue and then the output register before
// its first word is available. full is the queue's full flag; while the
// queue has room an element is taken every cycle, even while a result word
// is waiting. Configuration must be written over the apb port only while
// the block is idle (not enforced by the block); pready is always high.
// ----------------------------------------------------------------------------
module nonzero_coordinate_emitter
#(
    parameter int QUEUE_DEPTH = 4   // queued nonzero elements, 2 or more
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // element side
    input  wire logic                              push,
    output logic                                   full,
    input  wire nce_pkg::in_word_t                 item,
    // result side
    output logic                                   empty,
    input  wire logic                              pop,
    output nce_pkg::out_word_t                     result,
    // configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [nce_pkg::ADDR_BITS-1:0]     paddr,
    input  wire logic [nce_pkg::DATA_BITS-1:0]     pwdata,
    output logic      [nce_pkg::DATA_BITS-1:0]     prdata,
    output logic                                   pready
);

    nce_pkg::cfg_t  cfg;
    nce_pkg::hit_t  hit_in;
    nce_pkg::hit_t  hit_out;
    logic           hit_push;
    logic           hit_pop;
    logic           hit_empty;
    logic           accept;

    // an element is taken whenever the queue has room
    assign accept = push && !full;

    // register file
    nce_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // zero test, odometer and count
    nce_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .item     (item),
        .cfg      (cfg),
        .hit_push (hit_push),
        .hit      (hit_in)
    );

    // nonzero elements waiting for the result port
    nce_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (hit_push),
        .din   (hit_in),
        .pop   (hit_pop),
        .dout  (hit_out),
        .empty (hit_empty),
        .full  (full)
    );

    // per-axis result words behind an output register
    nce_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .hit_empty (hit_empty),
        .hit       (hit_out),
        .hit_pop   (hit_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule
`default_nettype wire
